/* hw/rtl/cstl_pkg.sv */
// Shared types and constants for the cache set tag lookup block.
package cstl_pkg;

  localparam int TAG_W        = 8;
  localparam int AGE_W        = 16;
  localparam int WAYS_DEFAULT = 2;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [AGE_W-1:0] age_t;

  // Line write request from the lookup logic to the way storage.
  typedef struct packed {
    logic we;
    logic fill;
    tag_t tag;
    age_t age;
  } upd_t;

endpackage

/* hw/rtl/cache_set_tag_lookup_lru.sv */
// Top level of one cache set: access register, lookup, way storage and result register.
//
//   Channel   Handshake          Fields
//   access    start / busy       tag
//   result    done (strobe)      hit, way, evicted_valid, evicted_tag
//
// An item accepted at one edge is registered, looked up against the set in the
// next cycle, and its result is then registered and shown on done.
// A new item may be accepted every cycle while busy is low; each lookup sees
// the state left by the item before it, because the set is written at the
// edge that registers the result. Throughput is one item per cycle when not busy.
// Synchronous reset empties the set; busy is high during reset and clears after it.
// The receiver cannot stall; each result is shown for exactly one cycle.
module cache_set_tag_lookup_lru
  import cstl_pkg::*;
#(
  parameter int NumWays = WAYS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  tag_t tag,
  output logic done,
  output logic hit,
  output logic way,
  output logic evicted_valid,
  output tag_t evicted_tag
);

  localparam int WayW = (NumWays > 1) ? $clog2(NumWays) : 1;

  logic               in_valid;
  tag_t               in_tag;
  logic [NumWays-1:0] valid;
  tag_t [NumWays-1:0] tags;
  age_t [NumWays-1:0] ages;
  logic               lk_hit;
  logic [WayW-1:0]    lk_way;
  logic               lk_ev_valid;
  tag_t               lk_ev_tag;
  upd_t               upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_tag <= tag;
    end
    if (in_valid) begin
      hit           <= lk_hit;
      way           <= lk_way[0];
      evicted_valid <= lk_ev_valid;
      evicted_tag   <= lk_ev_tag;
    end
  end

  cstl_lookup #(
    .NumWays (NumWays),
    .WayW    (WayW)
  ) u_lookup (
    .req      (in_valid),
    .tag      (in_tag),
    .valid    (valid),
    .tags     (tags),
    .ages     (ages),
    .hit      (lk_hit),
    .way_sel  (lk_way),
    .ev_valid (lk_ev_valid),
    .ev_tag   (lk_ev_tag),
    .upd      (upd)
  );

  cstl_ways #(
    .NumWays (NumWays),
    .WayW    (WayW)
  ) u_ways (
    .clk     (clk),
    .rst     (rst),
    .upd     (upd),
    .upd_way (lk_way),
    .valid   (valid),
    .tags    (tags),
    .ages    (ages)
  );

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("Registered item produced no result strobe.");

  a_fill_valid: assert property (@(posedge clk) disable iff (rst)
    (upd.we && upd.fill) |=> valid[$past(lk_way)])
    else $error("Filled way is not marked valid.");

  a_stamp_written: assert property (@(posedge clk) disable iff (rst)
    upd.we |=> (ages[$past(lk_way)] == $past(upd.age)))
    else $error("Accessed way did not take the new age stamp.");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && evicted_valid))
    else $error("A hit reported an eviction.");

endmodule

/* hw/rtl/cstl_ways.sv */
// Way storage of one set: valid bits, tags and age counters.
module cstl_ways
  import cstl_pkg::*;
#(
  parameter int NumWays = WAYS_DEFAULT,
  parameter int WayW    = (NumWays > 1) ? $clog2(NumWays) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  upd_t                     upd,
  input  logic [WayW-1:0]          upd_way,
  output logic [NumWays-1:0]       valid,
  output tag_t [NumWays-1:0]       tags,
  output age_t [NumWays-1:0]       ages
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      tags  <= '0;
      ages  <= '0;
    end else if (upd.we) begin
      for (int i = 0; i < NumWays; i++) begin
        if (upd_way == WayW'(i)) begin
          ages[i] <= upd.age;
          if (upd.fill) begin
            valid[i] <= 1'b1;
            tags[i]  <= upd.tag;
          end
        end
      end
    end
  end

endmodule

/* hw/rtl/cstl_lookup.sv */
// Tag compare, victim choice and age stamp for one access, as reduction trees.
module cstl_lookup
  import cstl_pkg::*;
#(
  parameter int NumWays = WAYS_DEFAULT,
  parameter int WayW    = (NumWays > 1) ? $clog2(NumWays) : 1
) (
  input  logic               req,
  input  tag_t               tag,
  input  logic [NumWays-1:0] valid,
  input  tag_t [NumWays-1:0] tags,
  input  age_t [NumWays-1:0] ages,
  output logic               hit,
  output logic [WayW-1:0]    way_sel,
  output logic               ev_valid,
  output tag_t               ev_tag,
  output upd_t               upd
);

  localparam int Leaves = 1 << WayW;
  localparam int Nodes  = 2 * Leaves - 1;

  logic [Nodes-1:0]           pres;
  logic [Nodes-1:0]           hit_f;
  logic [Nodes-1:0]           inv_f;
  logic [Nodes-1:0][WayW-1:0] hit_i;
  logic [Nodes-1:0][WayW-1:0] inv_i;
  logic [Nodes-1:0][WayW-1:0] min_i;
  age_t [Nodes-1:0]           min_a;
  tag_t [Nodes-1:0]           min_t;
  age_t [Nodes-1:0]           max_a;

  // Leaves are in way order, so the left child always holds the lower ways.
  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < NumWays) begin : g_way
      assign pres[Leaves-1+i]  = 1'b1;
      assign hit_f[Leaves-1+i] = valid[i] && (tags[i] == tag);
      assign inv_f[Leaves-1+i] = !valid[i];
      assign hit_i[Leaves-1+i] = WayW'(i);
      assign inv_i[Leaves-1+i] = WayW'(i);
      assign min_i[Leaves-1+i] = WayW'(i);
      assign min_a[Leaves-1+i] = ages[i];
      assign min_t[Leaves-1+i] = tags[i];
      assign max_a[Leaves-1+i] = ages[i];
    end else begin : g_pad
      assign pres[Leaves-1+i]  = 1'b0;
      assign hit_f[Leaves-1+i] = 1'b0;
      assign inv_f[Leaves-1+i] = 1'b0;
      assign hit_i[Leaves-1+i] = '0;
      assign inv_i[Leaves-1+i] = '0;
      assign min_i[Leaves-1+i] = '0;
      assign min_a[Leaves-1+i] = '0;
      assign min_t[Leaves-1+i] = '0;
      assign max_a[Leaves-1+i] = '0;
    end
  end

  for (genvar n = 0; n < Leaves - 1; n++) begin : g_node
    logic take_r;
    assign take_r   = pres[2*n+2] && (min_a[2*n+2] < min_a[2*n+1]);
    assign pres[n]  = pres[2*n+1] | pres[2*n+2];
    assign hit_f[n] = hit_f[2*n+1] | hit_f[2*n+2];
    assign hit_i[n] = hit_f[2*n+1] ? hit_i[2*n+1] : hit_i[2*n+2];
    assign inv_f[n] = inv_f[2*n+1] | inv_f[2*n+2];
    assign inv_i[n] = inv_f[2*n+1] ? inv_i[2*n+1] : inv_i[2*n+2];
    assign min_i[n] = take_r ? min_i[2*n+2] : min_i[2*n+1];
    assign min_a[n] = take_r ? min_a[2*n+2] : min_a[2*n+1];
    assign min_t[n] = take_r ? min_t[2*n+2] : min_t[2*n+1];
    assign max_a[n] = (max_a[2*n+2] > max_a[2*n+1]) ? max_a[2*n+2] : max_a[2*n+1];
  end

  always_comb begin
    hit      = hit_f[0];
    ev_valid = 1'b0;
    ev_tag   = '0;
    if (hit_f[0]) begin
      way_sel = hit_i[0];
    end else if (inv_f[0]) begin
      way_sel = inv_i[0];
    end else begin
      way_sel  = min_i[0];
      ev_valid = pres[0];
      ev_tag   = min_t[0];
    end
    upd.we   = req;
    upd.fill = !hit_f[0];
    upd.tag  = tag;
    upd.age  = max_a[0] + age_t'(1);
  end

endmodule
